FILE: rtl/stk_pkg.sv
// shared types for the word stack: action and status codes, cell controls
// and the sequencer state. no dependencies
package stk_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH = 3'd0,
      ACT_POP  = 3'd1,
      ACT_DUP  = 3'd2,
      ACT_SWAP = 3'd3,
      ACT_ROT  = 3'd4,
      ACT_PEEK = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // where a cell takes its next word from
   typedef enum logic [1:0] {
      SEL_HOLD  = 2'd0,
      SEL_UP    = 2'd1,
      SEL_DOWN  = 2'd2,
      SEL_DOWN2 = 2'd3
   } sel_type;

   typedef struct packed {
      sel_type sel;
      logic    hit;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RESP = 2'd2
   } state_type;

endpackage

FILE: rtl/stack_with_dup_swap_rot.sv
// top level of the word stack: sequencer, fill count and the row of stk_cell.
// uses stk_pkg and stk_cell
//
// A word is taken when start is high and busy is low; its result appears on
// the rsp_ ports, marked by rsp_strobe for one cycle, and cannot be held off.
// Every word is captured, then all cells shift, swap or rotate together (the
// top of the stack is cell zero), and then the popped or peeked word is
// gathered from the cell taps through an OR tree. busy falls in the cycle the
// result shows, so the next word may be taken then. There is no clearing pass
// after reset.
module stack_with_dup_swap_rot #(
   parameter int DEPTH     = 64,
   parameter int WORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_action,
   input  logic [31:0]                   req_push_value,
   input  logic [5:0]                    req_peek_offset,
   output logic                          rsp_strobe,
   output logic [31:0]                   rsp_value_out,
   output logic [1:0]                    rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_item_count
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CMP_BITS = (CNT_BITS > 6) ? CNT_BITS : 6;

   stk_pkg::state_type   state_ff;
   stk_pkg::state_type   state_in;
   stk_pkg::action_type  action_ff;
   logic [WORD_BITS-1:0] push_word_ff;
   logic [5:0]           offset_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic                 strobe_ff;
   logic [31:0]          value_ff;
   logic [1:0]           status_ff;
   logic [1:0]           status_in;
   logic [CNT_BITS-1:0]  rsp_count_ff;

   logic                 accept;
   logic                 exec_en;
   logic                 resp_en;
   stk_pkg::status_type  status;
   logic                 hit_en;
   logic [IDX_BITS-1:0]  hit_idx;
   logic [CMP_BITS-1:0]  off_ext;
   logic [CMP_BITS-1:0]  cnt_ext;
   logic [WORD_BITS-1:0] tap_or;

   stk_pkg::cell_ctl_type ctl [DEPTH];
   logic [WORD_BITS-1:0]  cell_word [DEPTH];
   logic [WORD_BITS-1:0]  cell_tap [DEPTH];

   assign accept = start && !busy;

   // next state
   always_comb begin
      case (state_ff)
         stk_pkg::ST_IDLE: state_in = accept ? stk_pkg::ST_EXEC : stk_pkg::ST_IDLE;
         stk_pkg::ST_EXEC: state_in = stk_pkg::ST_RESP;
         stk_pkg::ST_RESP: state_in = stk_pkg::ST_IDLE;
         default:          state_in = stk_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (state_ff)
         stk_pkg::ST_IDLE: begin
            busy = 1'b0; exec_en = 1'b0; resp_en = 1'b0;
         end
         stk_pkg::ST_EXEC: begin
            busy = 1'b1; exec_en = 1'b1; resp_en = 1'b0;
         end
         stk_pkg::ST_RESP: begin
            busy = 1'b1; exec_en = 1'b0; resp_en = 1'b1;
         end
         default: begin
            busy = 1'b0; exec_en = 1'b0; resp_en = 1'b0;
         end
      endcase
   end

   // status and count
   always_comb begin
      off_ext  = CMP_BITS'(offset_ff);
      cnt_ext  = CMP_BITS'(count_ff);
      status   = stk_pkg::STAT_OK;
      count_in = count_ff;
      hit_en   = 1'b0;
      hit_idx  = '0;
      case (action_ff)
         stk_pkg::ACT_PUSH: begin
            if (count_ff == CNT_BITS'(DEPTH)) status = stk_pkg::STAT_OVER;
            else count_in = count_ff + 1'b1;
         end
         stk_pkg::ACT_POP: begin
            if (count_ff == '0) begin
               status = stk_pkg::STAT_UNDER;
            end else begin
               count_in = count_ff - 1'b1;
               hit_en   = 1'b1;
            end
         end
         stk_pkg::ACT_DUP: begin
            if (count_ff == '0) status = stk_pkg::STAT_UNDER;
            else if (count_ff == CNT_BITS'(DEPTH)) status = stk_pkg::STAT_OVER;
            else count_in = count_ff + 1'b1;
         end
         stk_pkg::ACT_SWAP: begin
            if (count_ff < CNT_BITS'(2)) status = stk_pkg::STAT_UNDER;
         end
         stk_pkg::ACT_ROT: begin
            if (count_ff < CNT_BITS'(3)) status = stk_pkg::STAT_UNDER;
         end
         stk_pkg::ACT_PEEK: begin
            if (off_ext >= cnt_ext) begin
               status = stk_pkg::STAT_RANGE;
            end else begin
               hit_en  = 1'b1;
               hit_idx = IDX_BITS'(cnt_ext - off_ext - CMP_BITS'(1));
            end
         end
         default: ;
      endcase
      status_in = status;
   end

   // per-cell controls
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ctl[i].sel = stk_pkg::SEL_HOLD;
         ctl[i].hit = exec_en && hit_en && (hit_idx == IDX_BITS'(i));
      end
      if (exec_en && status == stk_pkg::STAT_OK) begin
         case (action_ff)
            stk_pkg::ACT_PUSH: begin
               for (int i = 0; i < DEPTH; i++) ctl[i].sel = stk_pkg::SEL_UP;
            end
            stk_pkg::ACT_POP: begin
               for (int i = 0; i < DEPTH; i++) ctl[i].sel = stk_pkg::SEL_DOWN;
            end
            stk_pkg::ACT_DUP: begin
               for (int i = 1; i < DEPTH; i++) ctl[i].sel = stk_pkg::SEL_UP;
            end
            stk_pkg::ACT_SWAP: begin
               ctl[0].sel = stk_pkg::SEL_DOWN;
               ctl[1].sel = stk_pkg::SEL_UP;
            end
            stk_pkg::ACT_ROT: begin
               ctl[0].sel = stk_pkg::SEL_DOWN2;
               ctl[1].sel = stk_pkg::SEL_UP;
               ctl[2].sel = stk_pkg::SEL_UP;
            end
            default: ;
         endcase
      end
   end

   // cell row, top at index zero
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_BITS-1:0] up_word;
      logic [WORD_BITS-1:0] down_word;
      logic [WORD_BITS-1:0] down2_word;

      if (g == 0) begin : g_top
         assign up_word = push_word_ff;
      end else begin : g_mid
         assign up_word = cell_word[g-1];
      end

      if (g + 1 < DEPTH) begin : g_dn
         assign down_word = cell_word[g+1];
      end else begin : g_dn_end
         assign down_word = '0;
      end

      if (g + 2 < DEPTH) begin : g_dn2
         assign down2_word = cell_word[g+2];
      end else begin : g_dn2_end
         assign down2_word = '0;
      end

      stk_cell #(
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl[g]),
         .up_word    (up_word),
         .down_word  (down_word),
         .down2_word (down2_word),
         .word       (cell_word[g]),
         .tap        (cell_tap[g])
      );
   end

   // taps are zero except the selected cell
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < DEPTH; i++) tap_or = tap_or | cell_tap[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= stk_pkg::ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= resp_en;
         if (exec_en) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff    <= stk_pkg::action_type'(req_action);
         push_word_ff <= WORD_BITS'(req_push_value);
         offset_ff    <= req_peek_offset;
      end
      if (exec_en) begin
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
      if (resp_en) value_ff <= 32'(tap_or);
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_value_out  = value_ff;
   assign rsp_status     = status_ff;
   assign rsp_item_count = rsp_count_ff;

endmodule

FILE: rtl/stk_cell.sv
// one stack cell: holds one word and reloads it from a neighbor or itself.
// also registers its word as a tap when selected for readout. uses stk_pkg
module stk_cell #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  stk_pkg::cell_ctl_type ctl,
   input  logic [WORD_BITS-1:0] up_word,
   input  logic [WORD_BITS-1:0] down_word,
   input  logic [WORD_BITS-1:0] down2_word,
   output logic [WORD_BITS-1:0] word,
   output logic [WORD_BITS-1:0] tap
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic [WORD_BITS-1:0] tap_ff;
   logic [WORD_BITS-1:0] tap_in;

   always_comb begin
      case (ctl.sel)
         stk_pkg::SEL_HOLD:  word_in = word_ff;
         stk_pkg::SEL_UP:    word_in = up_word;
         stk_pkg::SEL_DOWN:  word_in = down_word;
         stk_pkg::SEL_DOWN2: word_in = down2_word;
         default:            word_in = word_ff;
      endcase
      tap_in = ctl.hit ? word_ff : '0;
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      tap_ff  <= tap_in;
   end

   assign word = word_ff;
   assign tap  = tap_ff;

endmodule

FILE: rtl/stk_checker.sv
// port-level checks for the word stack, bound to stack_with_dup_swap_rot.
// uses stk_pkg
module stk_checker #(
   parameter int DEPTH = 64
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input logic [31:0]                rsp_value_out,
   input logic [1:0]                 rsp_status,
   input logic [$clog2(DEPTH+1)-1:0] rsp_item_count
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   a_resp_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("result not three cycles after accepted word");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted word");

   a_strobe_free: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy high while result shown");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != stk_pkg::STAT_OK) |-> rsp_value_out == '0)
      else $error("nonzero value on failed action");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item_count <= CNT_BITS'(DEPTH))
      else $error("item count above depth");

endmodule

bind stack_with_dup_swap_rot stk_checker #(
   .DEPTH (DEPTH)
) u_stk_checker (.*);
